FILE: hw/rtl/gbfd_pkg.sv
`timescale 1ns / 1ps

package gbfd_pkg;

  // Frame marks.
  localparam logic [7:0] SYNC_A = 8'hA0;
  localparam logic [7:0] SYNC_B = 8'hA2;
  localparam logic [7:0] END_A  = 8'hB0;
  localparam logic [7:0] END_B  = 8'hB3;

  // Length limit after reset.
  localparam logic [9:0] LIMIT_RESET = 10'd1023;

  // Configuration register map (index is paddr[2]).
  localparam int          PADDR_W          = 3;
  localparam logic [0:0]  REG_LENGTH_LIMIT = 1'b0;

  // Input kinds carried on tuser.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_FULL   = 3'd1,
    ST_BYTE   = 3'd2,
    ST_NONE   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

endpackage

FILE: hw/rtl/gps_binary_frame_deframer_core.sv
`timescale 1ns / 1ps

// Binary GPS frame deframer.
// The slave stream carries one item per transfer: tuser selects a push (0) of
// the received byte in tdata, or a pull (1) of the next payload byte of the
// oldest complete frame. Every item gives exactly one result on the master
// stream: status, payload byte, length, checksum, skipped count and the
// number of queued frames; tlast marks the final byte of a frame or an empty frame.
// Pushed bytes go into a byte ring; after each item a scanner walks the ring
// for A0 A2, length, payload, checksum, B0 B3 and queues a descriptor per
// frame. The scanner and the pulls share the ring's single read port, one
// byte per cycle. A pull that finds a frame reads its descriptor, then one
// payload byte (none for an empty frame); a push, or a pull that finds no
// frame, goes straight to the scan. The scan steps one byte past each
// unmatched position, each start rejected for its length and each start
// rejected at its end mark, and runs until it lacks bytes or queue space;
// then the result is registered at the output. One item is worked on at a time.
// A new item is taken while the previous result still waits at the output
// register; if the receiver stalls, the block holds the next result until
// the output register frees up. Reset empties the ring and the frame queue
// at once (no clearing pass) and sets length_limit to 1023.
// length_limit is written over the APB port at byte address 0.
module gps_binary_frame_deframer_core #(
  parameter int RING_DEPTH  = 2048,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Slave stream.
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [7:0]                              s_tdata,  // [7:0] data_byte
  input  logic                                    s_tuser,  // [0] action
  // Master stream.
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // [2:0] status, [10:3] payload_byte, [20:11] frame_length,
  // [36:21] frame_checksum, [52:37] skipped_count, then frames_waiting
  output logic [((53 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                                    m_tlast,  // last_of_frame
  // Configuration port.
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [gbfd_pkg::PADDR_W-1:0]            paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  import gbfd_pkg::*;

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int SW  = AW + 1;
  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int OW  = ((53 + FW + 7) / 8) * 8;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [9:0]    length;
    logic [15:0]   checksum;
    logic [15:0]   skipped;
  } desc_t;

  localparam int QW = $bits(desc_t);

  typedef enum logic [3:0] {
    S_IDLE, S_DESC, S_PBYTE, S_CHECK, S_B0, S_B1, S_L0, S_L1,
    S_C0, S_C1, S_E0, S_E1, S_FIN, S_OUT
  } state_t;

  // Ring address plus offset, wrapped once.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [10:0] off);
    logic [SW-1:0] s;
    s = {1'b0, base} + SW'(off);
    if (s >= SW'(RING_DEPTH)) begin
      s = s - SW'(RING_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_t          state;
  logic [AW-1:0]   wp;
  logic [AW-1:0]   sp;
  logic [AW-1:0]   rel;
  logic [9:0]      po;
  logic [15:0]     skip;
  logic [QIW-1:0]  q_head;
  logic [QIW-1:0]  q_tail;
  logic [FW-1:0]   fill;
  logic [9:0]      limit;
  logic [7:0]      hold;
  logic [9:0]      len;
  logic [15:0]     csum;
  logic [9:0]      cur_len;
  status_t         r_status;
  logic [7:0]      r_byte;
  logic            r_last;
  logic [9:0]      r_len;
  logic [15:0]     r_csum;
  logic [15:0]     r_skip;

  logic            accept;
  logic            cfg_wr;
  logic [AW-1:0]   wp_next;
  logic            ring_full;
  logic            ring_we;
  logic [AW-1:0]   rd_base;
  logic [10:0]     rd_off;
  logic [AW-1:0]   ring_raddr;
  logic [7:0]      ring_rdata;
  logic            q_we;
  desc_t           q_wdesc;
  logic [QW-1:0]   q_rdata;
  desc_t           q_desc;
  logic [SW-1:0]   avail_raw;
  logic [SW-1:0]   avail;
  logic [15:0]     len_now;
  logic            sync_ok;
  logic            end_ok;
  logic [QIW-1:0]  q_head_next;
  logic [QIW-1:0]  q_tail_next;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_LENGTH_LIMIT) ? {22'd0, limit} : 32'd0;

  // Push bookkeeping.
  assign wp_next   = ring_add(wp, 11'd1);
  assign ring_full = (wp_next == rel);
  assign ring_we   = accept && (s_tuser == ACT_PUSH) && !ring_full;

  // Bytes between scan and write pointers.
  assign avail_raw = {1'b0, wp} + SW'(RING_DEPTH) - {1'b0, sp};
  assign avail     = (avail_raw >= SW'(RING_DEPTH)) ? avail_raw - SW'(RING_DEPTH)
                                                     : avail_raw;

  assign len_now = {hold, ring_rdata};
  assign sync_ok = (hold == SYNC_A) && (ring_rdata == SYNC_B);
  assign end_ok  = (hold == END_A) && (ring_rdata == END_B);
  assign q_desc  = desc_t'(q_rdata);

  assign q_head_next = (q_head == QIW'(QUEUE_DEPTH - 1)) ? '0 : q_head + 1'b1;
  assign q_tail_next = (q_tail == QIW'(QUEUE_DEPTH - 1)) ? '0 : q_tail + 1'b1;

  // Ring read address for the byte needed in the next state.
  always_comb begin
    rd_base = sp;
    rd_off  = 11'd0;
    case (state)
      S_CHECK: rd_off = 11'd0;
      S_B0:    rd_off = 11'd1;
      S_B1:    rd_off = 11'd2;
      S_L0:    rd_off = 11'd3;
      S_L1:    rd_off = {1'b0, len_now[9:0]} + 11'd4;
      S_C0:    rd_off = {1'b0, len} + 11'd5;
      S_C1:    rd_off = {1'b0, len} + 11'd6;
      S_E0:    rd_off = {1'b0, len} + 11'd7;
      S_DESC: begin
        rd_base = q_desc.start;
        rd_off  = {1'b0, po} + 11'd4;
      end
      default: rd_off = 11'd0;
    endcase
  end

  assign ring_raddr = ring_add(rd_base, rd_off);

  // Queue write when a complete frame is found and the queue has room.
  assign q_we = (state == S_E1) && end_ok && (fill < FW'(QUEUE_DEPTH));
  always_comb begin
    q_wdesc.start    = sp;
    q_wdesc.length   = len;
    q_wdesc.checksum = csum;
    q_wdesc.skipped  = skip;
  end

  gbfd_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp),
    .wdata (s_tdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  gbfd_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_tail),
    .wdata (QW'(q_wdesc)),
    .raddr (q_head),
    .rdata (q_rdata)
  );

  // Sequencer: one action, then the scan, then the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      sp       <= '0;
      rel      <= '0;
      po       <= '0;
      skip     <= '0;
      q_head   <= '0;
      q_tail   <= '0;
      fill     <= '0;
      limit    <= LIMIT_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_LENGTH_LIMIT) begin
        limit <= pwdata[9:0];
      end
      // The output state loads the next result itself.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r_byte <= '0;
            r_last <= 1'b0;
            r_len  <= '0;
            r_csum <= '0;
            r_skip <= '0;
            if (s_tuser == ACT_PUSH) begin
              if (ring_full) begin
                r_status <= ST_FULL;
              end else begin
                r_status <= ST_PUSHED;
                wp       <= wp_next;
              end
              state <= S_CHECK;
            end else if (fill == '0) begin
              r_status <= ST_NONE;
              state    <= S_CHECK;
            end else begin
              state <= S_DESC;
            end
          end
        end
        S_DESC: begin
          r_len   <= q_desc.length;
          r_csum  <= q_desc.checksum;
          r_skip  <= q_desc.skipped;
          cur_len <= q_desc.length;
          if (q_desc.length == '0) begin
            r_status <= ST_EMPTY;
            r_last   <= 1'b1;
            q_head   <= q_head_next;
            fill     <= fill - 1'b1;
            po       <= '0;
            state    <= S_CHECK;
          end else begin
            state <= S_PBYTE;
          end
        end
        S_PBYTE: begin
          r_status <= ST_BYTE;
          r_byte   <= ring_rdata;
          if ({1'b0, po} + 11'd1 >= {1'b0, cur_len}) begin
            r_last <= 1'b1;
            q_head <= q_head_next;
            fill   <= fill - 1'b1;
            po     <= '0;
          end else begin
            po <= po + 1'b1;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= (avail < SW'(2)) ? S_FIN : S_B0;
        end
        S_B0: begin
          hold  <= ring_rdata;
          state <= S_B1;
        end
        S_B1: begin
          if (!sync_ok) begin
            if (skip != 16'hFFFF) begin
              skip <= skip + 1'b1;
            end
            sp    <= ring_add(sp, 11'd1);
            state <= S_CHECK;
          end else if (avail < SW'(4)) begin
            state <= S_FIN;
          end else begin
            state <= S_L0;
          end
        end
        S_L0: begin
          hold  <= ring_rdata;
          state <= S_L1;
        end
        S_L1: begin
          len <= len_now[9:0];
          if (len_now >= {6'd0, limit}) begin
            sp    <= ring_add(sp, 11'd1);
            state <= S_CHECK;
          end else if (avail < SW'(len_now[9:0]) + SW'(8)) begin
            state <= S_FIN;
          end else begin
            state <= S_C0;
          end
        end
        S_C0: begin
          hold  <= ring_rdata;
          state <= S_C1;
        end
        S_C1: begin
          csum  <= {hold, ring_rdata};
          state <= S_E0;
        end
        S_E0: begin
          hold  <= ring_rdata;
          state <= S_E1;
        end
        S_E1: begin
          if (!end_ok) begin
            sp    <= ring_add(sp, 11'd1);
            state <= S_CHECK;
          end else if (!q_we) begin
            state <= S_FIN;
          end else begin
            q_tail <= q_tail_next;
            fill   <= fill + 1'b1;
            skip   <= '0;
            sp     <= ring_add(sp, {1'b0, len} + 11'd8);
            state  <= S_CHECK;
          end
        end
        S_FIN: begin
          // Oldest byte still needed.
          rel   <= (fill != '0) ? q_desc.start : sp;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OW'({fill, r_skip, r_csum, r_len, r_byte, r_status});
            m_tlast  <= r_last;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The queue never holds more descriptors than it has entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(QUEUE_DEPTH))
    else $error("frame queue overfilled");

  // Queuing a frame restarts the skip count.
  a_skip_clear: assert property (@(posedge clk) disable iff (rst)
    q_we |=> (skip == '0))
    else $error("skip count not cleared after queuing a frame");

  // With nothing queued, no pull is in progress.
  a_offset_idle: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (po == '0))
    else $error("pull offset set with empty queue");

  // A push never lands on the oldest byte still needed.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> (ring_add(wp, 11'd1) != rel))
    else $error("push overwrote needed ring data");
`endif

endmodule

FILE: hw/rtl/gbfd_ram.sv
`timescale 1ns / 1ps

module gbfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
